[rtl/ftpg_pkg.sv]
// shared types, constants and helpers for the falling trail pixel generator
`timescale 1ns / 1ps

package ftpg_pkg;

   // defaults of the top-level parameters
   localparam int MAX_TRAILS_DEF = 128;
   localparam int MAX_TAIL_DEF   = 64;

   // field widths
   localparam int COL_W   = 8;
   localparam int ROW_W   = 11;
   localparam int TAIL_W  = 7;
   localparam int SPEED_W = 16;
   localparam int DIM_W   = 9;
   localparam int INTEN_W = 8;

   localparam logic [INTEN_W-1:0] FULL_INTENSITY = 8'd255;

   // depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // item actions
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   // register select (address bit 2)
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 9'd64;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 9'd64;
   localparam logic [DIM_W-1:0] DIM_MAX      = 9'd256;

   // one trail table entry
   typedef struct packed {
      logic [COL_W-1:0]          col;
      logic signed [ROW_W-1:0]   row;
      logic [TAIL_W-1:0]         tail;
      logic [SPEED_W-1:0]        speed;
   } entry_type;

   // work handed from front to back: advanced trail plus intensity step
   typedef struct packed {
      logic [COL_W-1:0]          col;
      logic signed [ROW_W-1:0]   row;
      logic [TAIL_W-1:0]         tail;
      logic [INTEN_W-1:0]        step_q;
      logic [TAIL_W-1:0]         step_r;
   } job_type;

   // clamp a panel dimension to 256, zero optionally read as one
   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic zero_as_one);
      logic [DIM_W-1:0] r;
      r = v;
      if (v > DIM_MAX) begin
         r = DIM_MAX;
      end else if (v == '0) begin
         r = zero_as_one ? DIM_W'(1) : '0;
      end
      return r;
   endfunction

endpackage

[rtl/falling_trail_pixel_generator.sv]
// top level of the falling trail pixel generator: registers, front, queue, back
//
//   channel   direction  handshake                  beat
//   req_      in         req_push / req_full        one load or step command
//   rsp_      out        rsp_empty / rsp_pop        one lit pixel
//   csr_      in/out     APB, pready tied high      one register write or read
//
// a load beat is taken while the front end is idle, which then stays ready
// a step beat holds the front end through its read, advance and write-back
// states, plus a divide when the trail wraps (column remainder) and one for
// a nonzero tail's fade step (255 / tail), on one shared bit-serial divider
// the back end walks the tail one position per cycle, up to the last position
// not above the panel, overlapping the next front-end step via a 2-entry queue
// a full output register stalls the walk; a full queue stalls the front end
// synchronous reset clears control state only; the trail table is not cleared
`timescale 1ns / 1ps

module falling_trail_pixel_generator #(
   parameter int MAX_TRAILS = ftpg_pkg::MAX_TRAILS_DEF,
   parameter int MAX_TAIL   = ftpg_pkg::MAX_TAIL_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // command beats
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_action,
   input  logic [6:0]                       req_trail_index,
   input  logic [ftpg_pkg::COL_W-1:0]       req_load_column,
   input  logic signed [ftpg_pkg::ROW_W-1:0] req_load_row,
   input  logic [ftpg_pkg::TAIL_W-1:0]      req_load_tail,
   input  logic [ftpg_pkg::SPEED_W-1:0]     req_load_speed,
   input  logic [ftpg_pkg::COL_W-1:0]       req_random_column,
   // pixel beats
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [ftpg_pkg::COL_W-1:0]       rsp_pixel_column,
   output logic [7:0]                       rsp_pixel_row,
   output logic [ftpg_pkg::INTEN_W-1:0]     rsp_pixel_intensity,
   output logic                             rsp_last_pixel,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [2:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import ftpg_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic             csr_wr;
   logic [DIM_W-1:0] width_eff, height_eff;

   logic             job_wr_valid, job_wr_ready;
   logic             job_rd_valid, job_rd_ready;
   job_type          job_wr, job_rd;

   // register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_WIDTH:  width_in  = csr_pwdata[DIM_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[DIM_W-1:0];
            default:    width_in  = width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // register reads
   assign csr_prdata = (csr_paddr[2] == REG_HEIGHT) ? {23'd0, height_ff} : {23'd0, width_ff};

   // panel dimensions as used by the datapath
   assign width_eff  = clamp_dim(width_ff, 1'b1);
   assign height_eff = clamp_dim(height_ff, 1'b0);

   ftpg_front #(
      .MAX_TRAILS (MAX_TRAILS),
      .MAX_TAIL   (MAX_TAIL)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .push          (req_push),
      .full          (req_full),
      .action        (req_action),
      .trail_index   (req_trail_index),
      .load_column   (req_load_column),
      .load_row      (req_load_row),
      .load_tail     (req_load_tail),
      .load_speed    (req_load_speed),
      .random_column (req_random_column),
      .width_eff     (width_eff),
      .height_eff    (height_eff),
      .job_valid     (job_wr_valid),
      .job_ready     (job_wr_ready),
      .job           (job_wr)
   );

   ftpg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (job_wr_valid),
      .wr_ready (job_wr_ready),
      .wr_data  (job_wr),
      .rd_valid (job_rd_valid),
      .rd_ready (job_rd_ready),
      .rd_data  (job_rd)
   );

   ftpg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_rd_valid),
      .job_ready       (job_rd_ready),
      .job             (job_rd),
      .height_eff      (height_eff),
      .empty           (rsp_empty),
      .pop             (rsp_pop),
      .pixel_column    (rsp_pixel_column),
      .pixel_row       (rsp_pixel_row),
      .pixel_intensity (rsp_pixel_intensity),
      .last_pixel      (rsp_last_pixel)
   );

endmodule

[rtl/ftpg_div.sv]
// iterative 8-bit restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module ftpg_div (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [7:0] dividend,
   input  logic [8:0] divisor,
   output logic       done,
   output logic [7:0] quot,
   output logic [8:0] rem
);
   localparam int STEPS = 8;
   localparam int CNT_W = $clog2(STEPS);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       dvd_ff, dvd_in;
   logic [8:0]       rem_ff, rem_in;
   logic [8:0]       dsr_ff, dsr_in;
   logic [9:0]       trial;
   logic             ge;

   // one restoring step
   always_comb begin
      trial   = {rem_ff, dvd_ff[7]};
      ge      = (trial >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? 9'(trial - {1'b0, dsr_ff}) : trial[8:0];
         dvd_in = {dvd_ff[6:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quot = dvd_ff;
   assign rem  = rem_ff;

endmodule

[rtl/ftpg_queue.sv]
// short job queue between front and back
`timescale 1ns / 1ps

module ftpg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  ftpg_pkg::job_type wr_data,
   output logic              rd_valid,
   input  logic              rd_ready,
   output ftpg_pkg::job_type rd_data
);
   import ftpg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign wr_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/ftpg_front.sv]
// front end: trail table, row advance, wrap and intensity step set-up
`timescale 1ns / 1ps

module ftpg_front #(
   parameter int MAX_TRAILS = ftpg_pkg::MAX_TRAILS_DEF,
   parameter int MAX_TAIL   = ftpg_pkg::MAX_TAIL_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic                          action,
   input  logic [6:0]                    trail_index,
   input  logic [ftpg_pkg::COL_W-1:0]    load_column,
   input  logic signed [ftpg_pkg::ROW_W-1:0] load_row,
   input  logic [ftpg_pkg::TAIL_W-1:0]   load_tail,
   input  logic [ftpg_pkg::SPEED_W-1:0]  load_speed,
   input  logic [ftpg_pkg::COL_W-1:0]    random_column,
   input  logic [ftpg_pkg::DIM_W-1:0]    width_eff,
   input  logic [ftpg_pkg::DIM_W-1:0]    height_eff,
   output logic                          job_valid,
   input  logic                          job_ready,
   output ftpg_pkg::job_type             job
);
   import ftpg_pkg::*;

   localparam int ADDR_W = (MAX_TRAILS > 1) ? $clog2(MAX_TRAILS) : 1;

   typedef enum logic [6:0] {
      F_IDLE = 7'b0000001,
      F_READ = 7'b0000010,
      F_ADV  = 7'b0000100,
      F_MOD  = 7'b0001000,
      F_WB   = 7'b0010000,
      F_TDIV = 7'b0100000,
      F_PUSH = 7'b1000000
   } front_state_type;

   front_state_type state_ff, state_in;

   entry_type               trail_mem [MAX_TRAILS];
   entry_type               rd_entry_ff;
   entry_type               wr_entry;
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;

   logic [ADDR_W-1:0]       addr_ff, addr_in;
   logic [COL_W-1:0]        rand_ff, rand_in;
   logic [COL_W-1:0]        col_ff, col_in;
   // one bit wider than the table so an overshoot past the bottom is seen before wrap
   logic signed [ROW_W:0]   row_ff, row_in;
   logic [TAIL_W-1:0]       tail_ff, tail_in;
   logic [SPEED_W-1:0]      speed_ff, speed_in;
   logic [INTEN_W-1:0]      q_ff, q_in;
   logic [TAIL_W-1:0]       r_ff, r_in;

   logic                    accept, idx_ok;
   logic [TAIL_W-1:0]       tail_sat;
   logic signed [19:0]      acc, acc_adj;
   logic signed [ROW_W:0]   above;
   logic                    wrap;

   logic                    div_start, div_done;
   logic [7:0]              div_dividend, div_quot;
   logic [8:0]              div_divisor, div_rem;

   assign full   = (state_ff != F_IDLE);
   assign accept = push && !full;
   assign idx_ok = (32'(trail_index) < MAX_TRAILS);

   // tail saturation on load
   assign tail_sat = (32'(load_tail) > MAX_TAIL) ? TAIL_W'(MAX_TAIL) : load_tail;

   // row advance with truncation toward zero
   always_comb begin
      acc     = $signed({rd_entry_ff.row, 8'd0}) + $signed({4'd0, rd_entry_ff.speed});
      acc_adj = acc + $signed({12'd0, {8{acc[19]}}});
   end

   // wrap test: row - tail above panel height
   always_comb begin
      above = row_ff - $signed({5'd0, tail_ff});
      wrap  = (above > $signed({3'd0, height_eff}));
   end

   // shared divider operands
   assign div_start    = ((state_ff == F_ADV) && wrap) ||
                         ((state_ff == F_WB) && (tail_ff != '0));
   assign div_dividend = (state_ff == F_ADV) ? rand_ff : FULL_INTENSITY;
   assign div_divisor  = (state_ff == F_ADV) ? width_eff : {2'd0, tail_ff};

   ftpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   // table write port: loads at accept, write-back after a step
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = addr_ff;
      wr_entry  = '{col: col_ff, row: row_ff[ROW_W-1:0], tail: tail_ff, speed: speed_ff};
      if (accept && (action == ACT_LOAD) && idx_ok) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(trail_index);
         wr_entry  = '{col: load_column, row: load_row, tail: tail_sat, speed: load_speed};
      end else if (state_ff == F_WB) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         trail_mem[mem_waddr] <= wr_entry;
      end
      rd_entry_ff <= trail_mem[ADDR_W'(trail_index)];
   end

   // step sequencer
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      rand_in  = rand_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      tail_in  = tail_ff;
      speed_in = speed_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept && (action == ACT_STEP) && idx_ok) begin
               addr_in  = ADDR_W'(trail_index);
               rand_in  = random_column;
               state_in = F_READ;
            end
         end
         F_READ: begin
            col_in   = rd_entry_ff.col;
            row_in   = acc_adj[ROW_W+8:8];
            tail_in  = rd_entry_ff.tail;
            speed_in = rd_entry_ff.speed;
            state_in = F_ADV;
         end
         F_ADV: begin
            if (wrap) begin
               row_in   = -$signed({5'd0, tail_ff});
               state_in = F_MOD;
            end else begin
               state_in = F_WB;
            end
         end
         F_MOD: begin
            if (div_done) begin
               col_in   = div_rem[COL_W-1:0];
               state_in = F_WB;
            end
         end
         F_WB: begin
            state_in = (tail_ff == '0) ? F_IDLE : F_TDIV;
         end
         F_TDIV: begin
            if (div_done) begin
               q_in     = div_quot;
               r_in     = div_rem[TAIL_W-1:0];
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      rand_ff  <= rand_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      tail_ff  <= tail_in;
      speed_ff <= speed_in;
      q_ff     <= q_in;
      r_ff     <= r_in;
   end

   // job to the back end
   assign job_valid = (state_ff == F_PUSH);
   assign job       = '{col: col_ff, row: row_ff[ROW_W-1:0], tail: tail_ff,
                        step_q: q_ff, step_r: r_ff};

endmodule

[rtl/ftpg_back.sv]
// back end: walks the tail, fades intensity, emits visible pixels
`timescale 1ns / 1ps

module ftpg_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         job_valid,
   output logic                         job_ready,
   input  ftpg_pkg::job_type            job,
   input  logic [ftpg_pkg::DIM_W-1:0]   height_eff,
   output logic                         empty,
   input  logic                         pop,
   output logic [ftpg_pkg::COL_W-1:0]   pixel_column,
   output logic [7:0]                   pixel_row,
   output logic [ftpg_pkg::INTEN_W-1:0] pixel_intensity,
   output logic                         last_pixel
);
   import ftpg_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_RUN  = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-2:0]   row_ff, row_in;
   logic [TAIL_W-1:0]  tail_ff, tail_in;
   logic [INTEN_W-1:0] a_ff, a_in;
   logic [TAIL_W-1:0]  b_ff, b_in;
   logic [TAIL_W-1:0]  j_ff, j_in;
   logic [TAIL_W-1:0]  end_ff, end_in;
   logic [INTEN_W-1:0] q_ff, q_in;
   logic [TAIL_W-1:0]  r_ff, r_in;

   logic               out_valid_ff, out_valid_in;
   logic [COL_W-1:0]   out_col_ff, out_col_in;
   logic [7:0]         out_row_ff, out_row_in;
   logic [INTEN_W-1:0] out_inten_ff, out_inten_in;
   logic               out_last_ff, out_last_in;

   logic               take, out_free, emit;
   logic [TAIL_W-1:0]  tail_m1;
   logic [ROW_W-2:0]   y;
   logic               visible, at_end;
   logic signed [TAIL_W:0] r_diff;

   assign job_ready = (state_ff == B_IDLE);
   assign take      = job_valid && job_ready;
   assign out_free  = !out_valid_ff || pop;
   assign tail_m1   = job.tail - 1'b1;

   // current tail position
   always_comb begin
      y       = row_ff - {3'd0, j_ff};
      visible = ({1'b0, y} < {2'd0, height_eff});
      at_end  = (j_ff == end_ff);
      emit    = (state_ff == B_RUN) && out_free && visible;
      r_diff  = $signed({1'b0, r_ff}) - $signed({1'b0, b_ff});
   end

   // walk sequencer; intensity kept as quotient and remainder of 255*(tail-j)/tail
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      tail_in  = tail_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      j_in     = j_ff;
      end_in   = end_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      case (state_ff)
         B_IDLE: begin
            // a head above the panel lights nothing
            if (take && !job.row[ROW_W-1]) begin
               col_in   = job.col;
               row_in   = job.row[ROW_W-2:0];
               tail_in  = job.tail;
               a_in     = job.step_q;
               b_in     = job.step_r;
               j_in     = '0;
               q_in     = FULL_INTENSITY;
               r_in     = '0;
               end_in   = ({4'd0, tail_m1} <= job.row) ? tail_m1 : job.row[TAIL_W-1:0];
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (out_free) begin
               j_in = j_ff + 1'b1;
               if (r_diff < 0) begin
                  r_in = TAIL_W'(r_diff + $signed({1'b0, tail_ff}));
                  q_in = q_ff - a_ff - 1'b1;
               end else begin
                  r_in = r_diff[TAIL_W-1:0];
                  q_in = q_ff - a_ff;
               end
               if (at_end) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_inten_in = out_inten_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_col_in   = col_ff;
         out_row_in   = y[7:0];
         out_inten_in = q_ff;
         out_last_in  = at_end;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      tail_ff      <= tail_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      j_ff         <= j_in;
      end_ff       <= end_in;
      q_ff         <= q_in;
      r_ff         <= r_in;
      out_col_ff   <= out_col_in;
      out_row_ff   <= out_row_in;
      out_inten_ff <= out_inten_in;
      out_last_ff  <= out_last_in;
   end

   assign empty           = !out_valid_ff;
   assign pixel_column    = out_col_ff;
   assign pixel_row       = out_row_ff;
   assign pixel_intensity = out_inten_ff;
   assign last_pixel      = out_last_ff;

endmodule

[test/tb.sv]
// self-checking testbench for the falling trail pixel generator
`timescale 1ns / 1ps

module tb;
   import ftpg_pkg::*;

   localparam int TRAIL_COUNT    = MAX_TRAILS_DEF;
   localparam int TAIL_LIMIT     = MAX_TAIL_DEF;
   localparam int SETTLE_CYCLES  = 300;
   localparam int WATCHDOG_LIMIT = 5000;

   // one command beat as driven onto the req_ ports
   typedef struct {
      logic                     action;
      logic [6:0]               index;
      logic [COL_W-1:0]         column;
      logic signed [ROW_W-1:0]  row;
      logic [TAIL_W-1:0]        tail;
      logic [SPEED_W-1:0]       speed;
      logic [COL_W-1:0]         rnd;
   } rain_beat_t;

   // one lit pixel as seen on the rsp_ ports
   typedef struct packed {
      logic [7:0] column;
      logic [7:0] row;
      logic [7:0] intensity;
      logic       last;
   } pixel_t;

   logic                    clock;
   logic                    reset;
   logic                    req_push;
   logic                    req_full;
   logic                    req_action;
   logic [6:0]              req_trail_index;
   logic [COL_W-1:0]        req_load_column;
   logic signed [ROW_W-1:0] req_load_row;
   logic [TAIL_W-1:0]       req_load_tail;
   logic [SPEED_W-1:0]      req_load_speed;
   logic [COL_W-1:0]        req_random_column;
   logic                    rsp_empty;
   logic                    rsp_pop;
   logic [COL_W-1:0]        rsp_pixel_column;
   logic [7:0]              rsp_pixel_row;
   logic [INTEN_W-1:0]      rsp_pixel_intensity;
   logic                    rsp_last_pixel;
   logic                    csr_psel;
   logic                    csr_penable;
   logic                    csr_pwrite;
   logic [2:0]              csr_paddr;
   logic [31:0]             csr_pwdata;
   logic [31:0]             csr_prdata;
   logic                    csr_pready;

   // shadow of the trail table and panel registers
   entry_type        trail_mem [TRAIL_COUNT];
   bit               trail_written [TRAIL_COUNT];
   int               written_list[$];
   logic [DIM_W-1:0] model_width;
   logic [DIM_W-1:0] model_height;
   pixel_t           pending_pixels[$];

   int errors;
   int loads_sent;
   int steps_sent;
   int wrap_count;
   int pixels_checked;
   int panel_settings;
   int send_idle_pct;
   int pop_stall_pct;
   int quiet_cycles;

   falling_trail_pixel_generator dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_action          (req_action),
      .req_trail_index     (req_trail_index),
      .req_load_column     (req_load_column),
      .req_load_row        (req_load_row),
      .req_load_tail       (req_load_tail),
      .req_load_speed      (req_load_speed),
      .req_random_column   (req_random_column),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_pixel_column    (rsp_pixel_column),
      .rsp_pixel_row       (rsp_pixel_row),
      .rsp_pixel_intensity (rsp_pixel_intensity),
      .rsp_last_pixel      (rsp_last_pixel),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // visible panel height, zero hides everything
   function automatic int eff_height();
      return (model_height > DIM_MAX) ? int'(DIM_MAX) : int'(model_height);
   endfunction

   // load or advance one trail and queue the pixels it lights
   function automatic void apply_rain_beat(rain_beat_t b);
      entry_type e;
      pixel_t    px;
      pixel_t    lit[$];
      int        w, h, tl, row_now, acc, head, y, j;
      e = trail_mem[b.index];
      if (b.action == ACT_LOAD) begin
         tl = (b.tail > TAIL_LIMIT) ? TAIL_LIMIT : int'(b.tail);
         e.col   = b.column;
         e.row   = b.row;
         e.tail  = TAIL_W'(tl);
         e.speed = b.speed;
         trail_mem[b.index] = e;
         if (!trail_written[b.index]) begin
            trail_written[b.index] = 1'b1;
            written_list.push_back(b.index);
         end
         return;
      end
      w = (model_width == 0) ? 1 : ((model_width > DIM_MAX) ? int'(DIM_MAX) : int'(model_width));
      h = eff_height();
      tl = e.tail;
      // fixed-point advance, truncated toward zero
      row_now = $signed(e.row);
      acc = row_now * 256 + int'(e.speed);
      head = acc / 256;
      // fell off the bottom: restart above the panel in a new column
      if (head - tl > h) begin
         head = -tl;
         e.col = COL_W'(int'(b.rnd) % w);
         wrap_count++;
      end
      e.row = ROW_W'(head);
      trail_mem[b.index] = e;
      // visible tail pixels, head first
      for (j = 0; j < tl; j++) begin
         y = head - j;
         if (y < 0 || y >= h) continue;
         px.column    = e.col;
         px.row       = 8'(y);
         px.intensity = 8'((int'(FULL_INTENSITY) * (tl - j)) / tl);
         px.last      = 1'b0;
         lit.push_back(px);
      end
      if (lit.size() != 0) begin
         lit[lit.size() - 1].last = 1'b1;
      end
      foreach (lit[k]) begin
         pending_pixels.push_back(lit[k]);
      end
   endfunction

   // send one command beat, with an optional idle gap first
   task automatic send_beat(rain_beat_t b);
      if ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_push          <= 1'b1;
      req_action        <= b.action;
      req_trail_index   <= b.index;
      req_load_column   <= b.column;
      req_load_row      <= b.row;
      req_load_tail     <= b.tail;
      req_load_speed    <= b.speed;
      req_random_column <= b.rnd;
      do @(posedge clock); while (req_full);
      apply_rain_beat(b);
      if (b.action == ACT_LOAD) begin
         loads_sent++;
      end else begin
         steps_sent++;
      end
   endtask

   task automatic load_trail(int index, int column, int row, int tail, int speed);
      rain_beat_t b;
      b.action = ACT_LOAD;
      b.index  = 7'(index);
      b.column = COL_W'(column);
      b.row    = ROW_W'(row);
      b.tail   = TAIL_W'(tail);
      b.speed  = SPEED_W'(speed);
      b.rnd    = '0;
      send_beat(b);
   endtask

   task automatic step_trail(int index, int rnd);
      rain_beat_t b;
      b.action = ACT_STEP;
      b.index  = 7'(index);
      b.column = '0;
      b.row    = '0;
      b.tail   = '0;
      b.speed  = '0;
      b.rnd    = COL_W'(rnd);
      send_beat(b);
   endtask

   // stop sending, wait for every pixel, then let trailing work finish
   task automatic wait_until_quiet(int extra);
      req_push <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   // apb write then read back one panel register
   task automatic write_panel_reg(logic reg_sel, logic [DIM_W-1:0] value);
      logic [31:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {reg_sel, 2'b00};
      csr_pwdata  <= {23'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == REG_WIDTH) begin
         model_width = value;
      end else begin
         model_height = value;
      end
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== 32'(value)) begin
         $error("register %0d readback: expected %0d, got %0d", reg_sel, value, readback);
         errors++;
      end
   endtask

   task automatic set_panel(int width, int height);
      wait_until_quiet(SETTLE_CYCLES);
      write_panel_reg(REG_WIDTH, DIM_W'(width));
      write_panel_reg(REG_HEIGHT, DIM_W'(height));
      panel_settings++;
   endtask

   // mostly steps on loaded trails, some loads near the panel, some noise
   task automatic run_random_beats(int count);
      rain_beat_t b;
      int         tl, r;
      repeat (count) begin
         b.action = ACT_STEP;
         b.index  = 7'($urandom);
         b.column = COL_W'($urandom);
         b.row    = ROW_W'($urandom);
         b.tail   = TAIL_W'($urandom);
         b.speed  = SPEED_W'($urandom);
         b.rnd    = COL_W'($urandom);
         if (written_list.size() == 0 || $urandom_range(99) < 25) begin
            b.action = ACT_LOAD;
            if (written_list.size() != 0 && $urandom_range(1) == 1) begin
               b.index = 7'(written_list[$urandom_range(written_list.size() - 1)]);
            end
            case ($urandom_range(9))
               0: begin
               end
               1: begin
                  b.tail = TAIL_W'(TAIL_LIMIT);
               end
               default: begin
                  b.tail = TAIL_W'($urandom_range(1, 12));
               end
            endcase
            tl = (b.tail > TAIL_LIMIT) ? TAIL_LIMIT : int'(b.tail);
            if ($urandom_range(4) != 0) begin
               r = int'($urandom_range(0, eff_height() + 2 * tl + 8)) - tl - 4;
               b.row = ROW_W'(r);
            end
            if ($urandom_range(9) < 7) begin
               b.speed = SPEED_W'($urandom_range(0, 1024));
            end
         end else begin
            b.index = 7'(written_list[$urandom_range(written_list.size() - 1)]);
         end
         send_beat(b);
      end
   endtask

   // hand-picked trails on the default panel
   task automatic test_directed_trails();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      load_trail(0, 5, 10, 4, 16'h0100);
      step_trail(0, 0);
      // top index, largest row and speed, tail saturates, wraps twice
      load_trail(127, 255, 1023, 127, 16'hFFFF);
      step_trail(127, 255);
      step_trail(127, 0);
      // zero tail at the lowest row
      load_trail(1, 0, -1024, 0, 0);
      step_trail(1, 77);
      // negative rows truncate toward zero, lit on the third step
      load_trail(2, 17, -3, 5, 16'h0080);
      step_trail(2, 0);
      step_trail(2, 0);
      step_trail(2, 0);
      // full tail clipped at the bottom of the panel
      load_trail(3, 40, 70, 64, 0);
      step_trail(3, 0);
      // just under one row per step
      load_trail(4, 128, 63, 1, 16'h00FF);
      step_trail(4, 0);
      // wrap takes a new column, then reappears at row zero
      load_trail(5, 9, 67, 2, 16'h0200);
      step_trail(5, 200);
      step_trail(5, 0);
      load_trail(6, 255, 0, 1, 0);
      step_trail(6, 0);
   endtask

   task automatic test_default_panel();
      set_panel(64, 64);
      send_idle_pct = 0;
      pop_stall_pct = 0;
      run_random_beats(40);
      // hold off until every expected pixel has been received
      wait_until_quiet(0);
      run_random_beats(40);
   endtask

   task automatic test_zero_width();
      set_panel(0, 32);
      send_idle_pct = 62;
      pop_stall_pct = 0;
      run_random_beats(60);
   endtask

   task automatic test_oversized_panel();
      set_panel(511, 511);
      send_idle_pct = 0;
      pop_stall_pct = 62;
      run_random_beats(70);
   endtask

   task automatic test_full_panel();
      set_panel(256, 256);
      send_idle_pct = 28;
      pop_stall_pct = 28;
      run_random_beats(60);
   endtask

   task automatic test_single_pixel_panel();
      set_panel(1, 1);
      send_idle_pct = 0;
      pop_stall_pct = 0;
      run_random_beats(50);
   endtask

   task automatic test_hidden_panel();
      set_panel(300, 0);
      send_idle_pct = 62;
      pop_stall_pct = 62;
      run_random_beats(30);
   endtask

   task automatic test_random_panels();
      repeat (3) begin
         set_panel($urandom_range(1, 256), $urandom_range(1, 256));
         send_idle_pct = 28;
         pop_stall_pct = 28;
         run_random_beats(40);
      end
   endtask

   // pixel beat checker and receiver stalls
   task automatic check_field(string name, logic [7:0] expv, logic [7:0] actv);
      if (actv !== expv) begin
         $error("%s: expected %0d, got %0d", name, expv, actv);
         errors++;
      end
   endtask

   always @(posedge clock) begin : pixel_checker
      pixel_t exp_px;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel beat with none expected: column %0d row %0d",
                   rsp_pixel_column, rsp_pixel_row);
            errors++;
         end else begin
            exp_px = pending_pixels.pop_front();
            check_field("pixel_column", exp_px.column, rsp_pixel_column);
            check_field("pixel_row", exp_px.row, rsp_pixel_row);
            check_field("pixel_intensity", exp_px.intensity, rsp_pixel_intensity);
            check_field("last_pixel", 8'(exp_px.last), 8'(rsp_last_pixel));
            pixels_checked++;
         end
      end
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // test sequence
   initial begin
      reset             = 1'b1;
      req_push          = 1'b0;
      req_action        = ACT_LOAD;
      req_trail_index   = '0;
      req_load_column   = '0;
      req_load_row      = '0;
      req_load_tail     = '0;
      req_load_speed    = '0;
      req_random_column = '0;
      rsp_pop           = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      model_width       = WIDTH_RESET;
      model_height      = HEIGHT_RESET;
      errors            = 0;
      loads_sent        = 0;
      steps_sent        = 0;
      wrap_count        = 0;
      pixels_checked    = 0;
      panel_settings    = 1;
      send_idle_pct     = 0;
      pop_stall_pct     = 0;
      quiet_cycles      = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_trails();
      test_default_panel();
      test_zero_width();
      test_oversized_panel();
      test_full_panel();
      test_single_pixel_panel();
      test_hidden_panel();
      test_random_panels();

      wait_until_quiet(SETTLE_CYCLES);
      $display("summary: %0d loads and %0d steps (%0d wraps) over %0d panel settings",
               loads_sent, steps_sent, wrap_count, panel_settings);
      $display("summary: %0d pixel beats checked, %0d mismatches", pixels_checked, errors);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
